// ===== rtl/ecr_pkg.sv =====
package ecr_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int SAT_W      = 32;
    localparam int WORD_W     = 32;
    localparam int PEN_W      = 31;
    localparam int LANES      = 3;
    localparam int PROD_W     = 2 * WORD_W;

    // ratio s: quotient bits below the 2^62 cap, remainder carries the fraction shift
    localparam int S_QW       = PROD_W - 1;
    localparam int S_RW       = PROD_W + FRAC_BITS;

    // mass weights, Q2.30; numerator is 2*m << 30
    localparam int W_FRAC     = 30;
    localparam int W_SHIFT    = W_FRAC + 1;
    localparam int W_QW       = WORD_W;
    localparam int W_DW       = WORD_W + 1;
    localparam int W_RW       = WORD_W + W_SHIFT;

    // square root of |c|^2, then push quotient |c_i|*pen/root
    localparam int ROOT_STEPS = WORD_W;
    localparam int P_QW       = PEN_W;
    localparam int P_RW       = 2 * WORD_W - 2;

    localparam int W_DLY      = S_QW - W_QW;
    localparam int PIPE_DEPTH = 3 + S_QW + 3;
    localparam int MAG_W      = S_QW + WORD_W - W_FRAC;

    typedef struct packed {
        logic [LANES-1:0][WORD_W-1:0] d_mag;
        logic [LANES-1:0]             d_neg;
        logic [LANES-1:0]             c_neg;
        logic                         dot_neg;
        logic                         degen;
        logic                         w_zero;
        logic                         s_ovf;
    } t_side;

endpackage

// ===== rtl/elastic_collision_response_core.sv =====
// Elastic collision response, Q16.16. One request per clock is accepted while the output
// skid stage is not full; each gives one result, the depth set by the 63-cell quotient
// chain that forms the ratio s = (dv.d)/(d.d). The square root and the push quotient run
// beside it in their own cell rows, then three multiply stages apply d and the mass weights.
// The whole pipeline holds only when the output skid stage is full.
module elastic_collision_response_core import ecr_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // mass_first, mass_second, rel_vel_x/y/z, rel_pos_x/y/z, contact_dir_x/y/z,
    // penetration_depth, one pad bit
    input  logic [383:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // first_dv_x/y/z, second_dv_x/y/z, push_x/y/z
    output logic [287:0] o_m_axis_tdata,
    // degenerate
    output logic [0:0]   o_m_axis_tuser
);

    function automatic logic [WORD_W-1:0] sat_enc(input logic [MAG_W-1:0] mag,
                                                  input logic neg);
        logic [MAG_W-1:0] lim;
        logic [MAG_W-1:0] m;
        lim = MAG_W'(1) << (SAT_W - 1);
        if (neg) begin
            m = (mag > lim) ? lim : mag;
            return WORD_W'(MAG_W'(0) - m);
        end
        m = (mag > lim - MAG_W'(1)) ? lim - MAG_W'(1) : mag;
        return WORD_W'(m);
    endfunction

    logic adv;
    logic [PIPE_DEPTH-1:0] r_vld;
    logic [PIPE_DEPTH-1:0] n_vld;

    logic        [WORD_W-1:0] in_m1, in_m2;
    logic signed [WORD_W-1:0] in_v [LANES];
    logic signed [WORD_W-1:0] in_d [LANES];
    logic signed [WORD_W-1:0] in_c [LANES];
    logic        [PEN_W-1:0]  in_pen;

    always_comb begin
        in_m1  = i_s_axis_tdata[31:0];
        in_m2  = i_s_axis_tdata[63:32];
        in_pen = i_s_axis_tdata[382:352];
        for (int i = 0; i < LANES; i++) begin
            in_v[i] = i_s_axis_tdata[64 + WORD_W*i +: WORD_W];
            in_d[i] = i_s_axis_tdata[160 + WORD_W*i +: WORD_W];
            in_c[i] = i_s_axis_tdata[256 + WORD_W*i +: WORD_W];
        end
    end

    // stage A: products
    logic signed [PROD_W-1:0] r_a_dot [LANES];
    logic        [PROD_W-1:0] r_a_dd  [LANES];
    logic        [PROD_W-1:0] r_a_cc  [LANES];
    logic signed [PROD_W-1:0] r_a_pc  [LANES];
    logic signed [WORD_W-1:0] r_a_d   [LANES];
    logic        [LANES-1:0]  r_a_cneg;
    logic        [WORD_W-1:0] r_a_m1, r_a_m2;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < LANES; i++) begin
                r_a_dot[i]  <= in_v[i] * in_d[i];
                r_a_dd[i]   <= in_d[i] * in_d[i];
                r_a_cc[i]   <= in_c[i] * in_c[i];
                r_a_pc[i]   <= in_c[i] * $signed({1'b0, in_pen});
                r_a_d[i]    <= in_d[i];
                r_a_cneg[i] <= in_c[i][WORD_W-1];
            end
            r_a_m1 <= in_m1;
            r_a_m2 <= in_m2;
        end
    end

    // stage B: sums and magnitudes
    logic signed [PROD_W+1:0] dot_sum;
    logic [PROD_W-1:0] r_b_dot_mag, r_b_dd, r_b_cc;
    logic              r_b_dot_neg;
    logic [LANES-1:0][P_RW-1:0]   r_b_pc;
    logic [LANES-1:0][WORD_W-1:0] r_b_dmag;
    logic [LANES-1:0]  r_b_dneg, r_b_cneg;
    logic [W_DW-1:0]   r_b_sum;
    logic [WORD_W-1:0] r_b_m1, r_b_m2;

    assign dot_sum = (PROD_W+2)'(r_a_dot[0]) + (PROD_W+2)'(r_a_dot[1])
                   + (PROD_W+2)'(r_a_dot[2]);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_dot_neg <= dot_sum[PROD_W+1];
            r_b_dot_mag <= PROD_W'(dot_sum[PROD_W+1] ? -dot_sum : dot_sum);
            r_b_dd      <= r_a_dd[0] + r_a_dd[1] + r_a_dd[2];
            r_b_cc      <= r_a_cc[0] + r_a_cc[1] + r_a_cc[2];
            for (int i = 0; i < LANES; i++) begin
                r_b_pc[i]   <= P_RW'(r_a_pc[i][PROD_W-1] ? -r_a_pc[i] : r_a_pc[i]);
                r_b_dmag[i] <= WORD_W'(r_a_d[i][WORD_W-1] ? -(WORD_W+1)'(r_a_d[i])
                                                          : (WORD_W+1)'(r_a_d[i]));
                r_b_dneg[i] <= r_a_d[i][WORD_W-1];
            end
            r_b_cneg <= r_a_cneg;
            r_b_sum  <= W_DW'(r_a_m1) + W_DW'(r_a_m2);
            r_b_m1   <= r_a_m1;
            r_b_m2   <= r_a_m2;
        end
    end

    // stage C: chain operands, overflow of s and degenerate checks
    logic [S_RW-1:0]   r_c_srem;
    logic [PROD_W-1:0] r_c_dd, r_c_cc;
    logic [W_RW-1:0]   r_c_num1, r_c_num2;
    logic [W_DW-1:0]   r_c_sum;
    logic [LANES-1:0][P_RW-1:0] r_c_pc;
    t_side             r_c_side;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c_srem <= {r_b_dot_mag, {FRAC_BITS{1'b0}}};
            r_c_dd   <= r_b_dd;
            r_c_cc   <= r_b_cc;
            r_c_num1 <= {r_b_m2, {W_SHIFT{1'b0}}};
            r_c_num2 <= {r_b_m1, {W_SHIFT{1'b0}}};
            r_c_sum  <= r_b_sum;
            r_c_pc   <= r_b_pc;
            r_c_side.d_mag   <= r_b_dmag;
            r_c_side.d_neg   <= r_b_dneg;
            r_c_side.c_neg   <= r_b_cneg;
            r_c_side.dot_neg <= r_b_dot_neg;
            r_c_side.degen   <= (r_b_dd == '0) || (r_b_cc == '0);
            r_c_side.w_zero  <= (r_b_sum == '0);
            r_c_side.s_ovf   <= (r_b_dot_mag >> (S_QW - FRAC_BITS)) >= r_b_dd;
        end
    end

    // ratio s
    logic [S_RW-1:0]   s_rem [0:S_QW];
    logic [PROD_W-1:0] s_den [0:S_QW];
    logic [S_QW-1:0]   s_quo [0:S_QW];

    assign s_rem[0] = r_c_srem;
    assign s_den[0] = r_c_dd;
    assign s_quo[0] = '0;

    for (genvar k = 0; k < S_QW; k++) begin : g_s
        ecr_div_cell #(.RW(S_RW), .DW(PROD_W), .QW(S_QW), .BIT(S_QW - 1 - k)) u_cell (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_rem (s_rem[k]),
            .i_den (s_den[k]),
            .i_quo (s_quo[k]),
            .o_rem (s_rem[k+1]),
            .o_den (s_den[k+1]),
            .o_quo (s_quo[k+1])
        );
    end

    // mass weights
    logic [W_RW-1:0] w_rem [2][0:W_QW];
    logic [W_DW-1:0] w_den [2][0:W_QW];
    logic [W_QW-1:0] w_quo [2][0:W_QW];
    logic [1:0][W_QW-1:0] w_dly;

    assign w_rem[0][0] = r_c_num1;
    assign w_rem[1][0] = r_c_num2;

    for (genvar l = 0; l < 2; l++) begin : g_wl
        assign w_den[l][0] = r_c_sum;
        assign w_quo[l][0] = '0;
        for (genvar k = 0; k < W_QW; k++) begin : g_w
            ecr_div_cell #(.RW(W_RW), .DW(W_DW), .QW(W_QW), .BIT(W_QW - 1 - k)) u_cell (
                .i_clk (i_clk),
                .i_en  (adv),
                .i_rem (w_rem[l][k]),
                .i_den (w_den[l][k]),
                .i_quo (w_quo[l][k]),
                .o_rem (w_rem[l][k+1]),
                .o_den (w_den[l][k+1]),
                .o_quo (w_quo[l][k+1])
            );
        end
    end

    ecr_delay #(.W(2 * W_QW), .DEPTH(W_DLY)) u_w_dly (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_d   ({w_quo[1][W_QW], w_quo[0][W_QW]}),
        .o_q   (w_dly)
    );

    // |c| root
    logic [PROD_W-1:0] q_rad [0:ROOT_STEPS];
    logic [PROD_W-1:0] q_res [0:ROOT_STEPS];

    assign q_rad[0] = r_c_cc;
    assign q_res[0] = '0;

    for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_q
        ecr_sqrt_cell #(.STEP(ROOT_STEPS - 1 - k)) u_cell (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_rad (q_rad[k]),
            .i_res (q_res[k]),
            .o_rad (q_rad[k+1]),
            .o_res (q_res[k+1])
        );
    end

    // push quotient
    logic [LANES-1:0][P_RW-1:0] pc_dly;
    logic [P_RW-1:0]   p_rem [LANES][0:P_QW];
    logic [WORD_W-1:0] p_den [LANES][0:P_QW];
    logic [P_QW-1:0]   p_quo [LANES][0:P_QW];

    ecr_delay #(.W(LANES * P_RW), .DEPTH(ROOT_STEPS)) u_pc_dly (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_d   (r_c_pc),
        .o_q   (pc_dly)
    );

    for (genvar l = 0; l < LANES; l++) begin : g_pl
        assign p_rem[l][0] = pc_dly[l];
        assign p_den[l][0] = q_res[ROOT_STEPS][WORD_W-1:0];
        assign p_quo[l][0] = '0;
        for (genvar k = 0; k < P_QW; k++) begin : g_p
            ecr_div_cell #(.RW(P_RW), .DW(WORD_W), .QW(P_QW), .BIT(P_QW - 1 - k)) u_cell (
                .i_clk (i_clk),
                .i_en  (adv),
                .i_rem (p_rem[l][k]),
                .i_den (p_den[l][k]),
                .i_quo (p_quo[l][k]),
                .o_rem (p_rem[l][k+1]),
                .o_den (p_den[l][k+1]),
                .o_quo (p_quo[l][k+1])
            );
        end
    end

    t_side side_dly;

    ecr_delay #(.W($bits(t_side)), .DEPTH(S_QW)) u_side_dly (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_d   (r_c_side),
        .o_q   (side_dly)
    );

    // M1: s * |d_i|
    localparam logic [S_QW-1:0] S_CAP = S_QW'(1) << (S_QW - 1);

    logic [S_QW-1:0] s_val;
    logic [S_QW+WORD_W-W_QW-1:0] r_m1_phi [LANES];
    logic [PROD_W-1:0]           r_m1_plo [LANES];
    logic [W_QW-1:0]             r_m1_w1, r_m1_w2;
    logic [LANES-1:0][P_QW-1:0]  r_m1_push;
    t_side                       r_m1_side;

    always_comb begin
        s_val = s_quo[S_QW];
        if (side_dly.s_ovf || (s_val > S_CAP)) begin
            s_val = S_CAP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < LANES; i++) begin
                r_m1_phi[i]  <= s_val[S_QW-1:WORD_W] * side_dly.d_mag[i];
                r_m1_plo[i]  <= s_val[WORD_W-1:0] * side_dly.d_mag[i];
                r_m1_push[i] <= p_quo[i][P_QW];
            end
            r_m1_w1   <= side_dly.w_zero ? '0 : w_dly[0];
            r_m1_w2   <= side_dly.w_zero ? '0 : w_dly[1];
            r_m1_side <= side_dly;
        end
    end

    // M2: sd = (s*|d|) >> FRAC_BITS, capped
    localparam int SD_PW = S_QW + WORD_W;

    logic [SD_PW-1:0] sd_full [LANES];
    logic [S_QW-1:0]  r_m2_sd [LANES];
    logic [W_QW-1:0]  r_m2_w1, r_m2_w2;
    logic [LANES-1:0][P_QW-1:0] r_m2_push;
    t_side            r_m2_side;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            sd_full[i] = ((SD_PW'(r_m1_phi[i]) << WORD_W) + SD_PW'(r_m1_plo[i])) >> FRAC_BITS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < LANES; i++) begin
                r_m2_sd[i] <= (sd_full[i] > SD_PW'(S_CAP)) ? S_CAP : S_QW'(sd_full[i]);
            end
            r_m2_w1   <= r_m1_w1;
            r_m2_w2   <= r_m1_w2;
            r_m2_push <= r_m1_push;
            r_m2_side <= r_m1_side;
        end
    end

    // M3: sd * w
    logic [S_QW+W_QW-WORD_W-1:0] r_m3_ahi [LANES];
    logic [PROD_W-1:0]           r_m3_alo [LANES];
    logic [S_QW+W_QW-WORD_W-1:0] r_m3_bhi [LANES];
    logic [PROD_W-1:0]           r_m3_blo [LANES];
    logic [LANES-1:0][P_QW-1:0]  r_m3_push;
    t_side                       r_m3_side;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < LANES; i++) begin
                r_m3_ahi[i] <= r_m2_sd[i][S_QW-1:WORD_W] * r_m2_w1;
                r_m3_alo[i] <= r_m2_sd[i][WORD_W-1:0] * r_m2_w1;
                r_m3_bhi[i] <= r_m2_sd[i][S_QW-1:WORD_W] * r_m2_w2;
                r_m3_blo[i] <= r_m2_sd[i][WORD_W-1:0] * r_m2_w2;
            end
            r_m3_push <= r_m2_push;
            r_m3_side <= r_m2_side;
        end
    end

    // M4: final scale, sign and saturation
    localparam int FP_W = S_QW + W_QW;

    logic [FP_W-1:0]  fa [LANES];
    logic [FP_W-1:0]  fb [LANES];
    logic [287:0]     n_data;
    logic             n_degen;
    logic             sd_neg;

    always_comb begin
        n_data  = '0;
        n_degen = r_m3_side.degen;
        sd_neg  = 1'b0;
        for (int i = 0; i < LANES; i++) begin
            fa[i] = ((FP_W'(r_m3_ahi[i]) << WORD_W) + FP_W'(r_m3_alo[i])) >> W_FRAC;
            fb[i] = ((FP_W'(r_m3_bhi[i]) << WORD_W) + FP_W'(r_m3_blo[i])) >> W_FRAC;
            sd_neg = r_m3_side.dot_neg ^ r_m3_side.d_neg[i];
            if (!r_m3_side.degen) begin
                n_data[WORD_W*i +: WORD_W]       = sat_enc(MAG_W'(fa[i]), !sd_neg);
                n_data[WORD_W*(3+i) +: WORD_W]   = sat_enc(MAG_W'(fb[i]), sd_neg);
                n_data[WORD_W*(6+i) +: WORD_W]   = sat_enc(MAG_W'(r_m3_push[i]),
                                                           r_m3_side.c_neg[i]);
            end
        end
    end

    // valid tracking and output with skid
    logic         r_out_vld, r_skid_vld;
    logic [287:0] r_out_data, r_skid_data;
    logic         r_out_degen, r_skid_degen;
    logic         out_fire, tail_vld;

    assign adv      = !r_skid_vld;
    assign out_fire = r_out_vld && i_m_axis_tready;
    assign tail_vld = adv && r_vld[PIPE_DEPTH-1];
    assign n_vld    = adv ? {r_vld[PIPE_DEPTH-2:0], i_s_axis_tvalid} : r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
            if (r_skid_vld) begin
                if (out_fire) begin
                    r_out_vld  <= 1'b1;
                    r_skid_vld <= 1'b0;
                end
            end else if (!r_out_vld || out_fire) begin
                r_out_vld <= tail_vld;
            end else if (tail_vld) begin
                r_skid_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (out_fire) begin
                r_out_data  <= r_skid_data;
                r_out_degen <= r_skid_degen;
            end
        end else if (!r_out_vld || out_fire) begin
            r_out_data  <= n_data;
            r_out_degen <= n_degen;
        end else begin
            r_skid_data  <= n_data;
            r_skid_degen <= n_degen;
        end
    end

    assign o_s_axis_tready   = adv;
    assign o_m_axis_tvalid   = r_out_vld;
    assign o_m_axis_tdata    = r_out_data;
    assign o_m_axis_tuser[0] = r_out_degen;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid holds a request while output is empty");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> (o_m_axis_tdata == '0))
        else $error("degenerate result carries nonzero changes");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!adv && i_rst_n) |=> $stable(r_vld))
        else $error("pipeline moved while stalled");

endmodule

// ===== rtl/ecr_div_cell.sv =====
module ecr_div_cell #(
    parameter int RW  = 80,
    parameter int DW  = 64,
    parameter int QW  = 63,
    parameter int BIT = 0
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [RW-1:0] i_rem,
    input  logic [DW-1:0] i_den,
    input  logic [QW-1:0] i_quo,
    output logic [RW-1:0] o_rem,
    output logic [DW-1:0] o_den,
    output logic [QW-1:0] o_quo
);

    localparam int TW = (RW > DW + BIT) ? RW : DW + BIT;

    logic [TW-1:0] trial;
    logic [TW-1:0] rem_x;
    logic          fits;
    logic [RW-1:0] n_rem;
    logic [QW-1:0] n_quo;
    logic [RW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [QW-1:0] r_quo;

    always_comb begin
        trial = TW'(i_den) << BIT;
        rem_x = TW'(i_rem);
        fits  = rem_x >= trial;
        n_rem = fits ? RW'(rem_x - trial) : i_rem;
        n_quo = fits ? (i_quo | (QW'(1) << BIT)) : i_quo;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_den <= i_den;
            r_quo <= n_quo;
        end
    end

    assign o_rem = r_rem;
    assign o_den = r_den;
    assign o_quo = r_quo;

endmodule

// ===== rtl/ecr_sqrt_cell.sv =====
module ecr_sqrt_cell import ecr_pkg::*; #(
    parameter int STEP = 0
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [PROD_W-1:0] i_rad,
    input  logic [PROD_W-1:0] i_res,
    output logic [PROD_W-1:0] o_rad,
    output logic [PROD_W-1:0] o_res
);

    localparam logic [PROD_W:0] BITV = {{PROD_W{1'b0}}, 1'b1} << (2 * STEP);

    logic [PROD_W:0]   trial;
    logic              fits;
    logic [PROD_W-1:0] n_rad;
    logic [PROD_W-1:0] n_res;
    logic [PROD_W-1:0] r_rad;
    logic [PROD_W-1:0] r_res;

    always_comb begin
        trial = {1'b0, i_res} + BITV;
        fits  = {1'b0, i_rad} >= trial;
        n_rad = fits ? PROD_W'({1'b0, i_rad} - trial) : i_rad;
        n_res = fits ? PROD_W'(({1'b0, i_res} >> 1) + BITV) : (i_res >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad <= n_rad;
            r_res <= n_res;
        end
    end

    assign o_rad = r_rad;
    assign o_res = r_res;

endmodule

// ===== rtl/ecr_delay.sv =====
module ecr_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_tap [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_tap[k] <= r_tap[k-1];
            end
        end
    end

    assign o_q = r_tap[DEPTH-1];

endmodule
